// ===== sv/rma_pkg.sv =====
// ----------------------------------------------------------------------------
// rma_pkg
// Shared widths, register indexes, state encoding and the command and status
// bundles that join the row moving average controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rma_pkg;

   localparam int MAX_ROW     = 256;
   localparam int SAMPLE_BITS = 16;

   localparam int ADDR_BITS = $clog2(MAX_ROW);
   localparam int LEN_BITS  = $clog2(MAX_ROW + 1);
   localparam int CFG_BITS  = 9;
   localparam int IDX_BITS  = 4;
   // Window sum of up to MAX_ROW adds and MAX_ROW removals, plus sign.
   localparam int SUM_BITS  = SAMPLE_BITS + ADDR_BITS + 2;
   localparam int CNT_BITS  = $clog2(SUM_BITS);

   localparam logic [IDX_BITS-1:0] REG_ROW_LENGTH   = IDX_BITS'(0);
   localparam logic [IDX_BITS-1:0] REG_OUTPUT_COUNT = IDX_BITS'(1);

   localparam logic [CFG_BITS-1:0] ROW_LENGTH_RESET   = CFG_BITS'(16);
   localparam logic [CFG_BITS-1:0] OUTPUT_COUNT_RESET = CFG_BITS'(4);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DIVIDE,
      ST_PUSH
   } state_type;

   typedef struct packed {
      logic accept;
      logic fetch;
      logic div_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ===== sv/rma_ram.sv =====
// ----------------------------------------------------------------------------
// rma_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module rma_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== sv/rma_ctrl.sv =====
// ----------------------------------------------------------------------------
// rma_ctrl
// Sequencer for one sample: take it, update the window, run the divider
// when an average is due, then hand the average to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rma_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire rma_pkg::status_type status,
   output rma_pkg::cmd_type         cmd
);
   import rma_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = status.emit ? ST_DIVIDE : ST_IDLE;
         end
         ST_DIVIDE: begin
            if (status.div_last) state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            // hold off while reset is asserted so no item is dropped
            req_tready = !reset;
            cmd.accept = req_tvalid && !reset;
         end
         ST_FETCH:  cmd.fetch    = 1'b1;
         ST_DIVIDE: cmd.div_step = 1'b1;
         ST_PUSH:   cmd.load_out = status.out_free;
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/rma_dp.sv =====
// ----------------------------------------------------------------------------
// rma_dp
// Datapath: configuration registers, window store, running sum, restoring
// divider (one quotient bit per cycle) and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rma_dp (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [rma_pkg::IDX_BITS-1:0]    csr_index,
   input  wire logic [rma_pkg::CFG_BITS-1:0]    csr_data,
   input  wire logic [rma_pkg::SAMPLE_BITS-1:0] req_tdata,
   input  wire rma_pkg::cmd_type                cmd,
   output rma_pkg::status_type                  status,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [rma_pkg::SAMPLE_BITS-1:0]      rsp_tdata,
   output logic                                 rsp_tlast
);
   import rma_pkg::*;

   localparam logic [SUM_BITS-1:0] MAG_POS_LIMIT = SUM_BITS'(2 ** (SAMPLE_BITS - 1) - 1);
   localparam logic [SUM_BITS-1:0] MAG_NEG_LIMIT = SUM_BITS'(2 ** (SAMPLE_BITS - 1));
   localparam logic [SAMPLE_BITS-1:0] AVG_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] AVG_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(SUM_BITS - 1);

   logic [CFG_BITS-1:0]           row_length_ff, row_length_in;
   logic [CFG_BITS-1:0]           output_count_ff, output_count_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [LEN_BITS-1:0]           win_ff, win_in;
   logic                          need_sub_ff, need_sub_in;
   logic                          emit_ff, emit_in;
   logic                          row_end_ff, row_end_in;
   logic [ADDR_BITS-1:0]          pos_ff, pos_in;
   logic [ADDR_BITS-1:0]          ptr_ff, ptr_in;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [LEN_BITS-1:0]           rem_ff, rem_in;
   logic [SUM_BITS-1:0]           quo_ff, quo_in;
   logic                          neg_ff, neg_in;
   logic [CNT_BITS-1:0]           cnt_ff, cnt_in;
   logic                          out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0]        avg_ff, avg_in;
   logic                          out_last_ff, out_last_in;

   logic [LEN_BITS-1:0]           row_len_eff, out_cnt_eff, win_eff;
   logic [LEN_BITS-1:0]           pos_next;
   logic [SAMPLE_BITS-1:0]        old_sample;
   logic signed [SUM_BITS-1:0]    old_term, new_sum;
   logic [LEN_BITS:0]             shifted, trial;
   logic [SUM_BITS-1:0]           neg_quo;

   assign csr_ready = !reset;

   // Clamp the configuration to legal values and derive the window length.
   always_comb begin
      if (row_length_ff == '0) begin
         row_len_eff = LEN_BITS'(1);
      end else if (32'(row_length_ff) > 32'(MAX_ROW)) begin
         row_len_eff = LEN_BITS'(MAX_ROW);
      end else begin
         row_len_eff = LEN_BITS'(row_length_ff);
      end
      if (output_count_ff == '0) begin
         out_cnt_eff = LEN_BITS'(1);
      end else if (32'(output_count_ff) > 32'(row_len_eff)) begin
         out_cnt_eff = row_len_eff;
      end else begin
         out_cnt_eff = LEN_BITS'(output_count_ff);
      end
      win_eff  = row_len_eff - out_cnt_eff + LEN_BITS'(1);
      pos_next = LEN_BITS'(pos_ff) + LEN_BITS'(1);
   end

   rma_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_ROW)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.fetch),
      .wr_addr (ptr_ff),
      .wr_data (sample_ff),
      .rd_en   (cmd.accept),
      .rd_addr (ptr_ff - win_eff[ADDR_BITS-1:0]),
      .rd_data (old_sample)
   );

   always_comb begin
      old_term = need_sub_ff ? SUM_BITS'($signed(old_sample)) : '0;
      new_sum  = sum_ff + SUM_BITS'(sample_ff) - old_term;
      shifted  = {rem_ff, quo_ff[SUM_BITS-1]};
      trial    = shifted - {1'b0, win_ff};
      neg_quo  = SUM_BITS'(0) - quo_ff;
   end

   always_comb begin
      row_length_in   = row_length_ff;
      output_count_in = output_count_ff;
      sample_in       = sample_ff;
      win_in          = win_ff;
      need_sub_in     = need_sub_ff;
      emit_in         = emit_ff;
      row_end_in      = row_end_ff;
      pos_in          = pos_ff;
      ptr_in          = ptr_ff;
      sum_in          = sum_ff;
      rem_in          = rem_ff;
      quo_in          = quo_ff;
      neg_in          = neg_ff;
      cnt_in          = cnt_ff;
      out_valid_in    = out_valid_ff;
      avg_in          = avg_ff;
      out_last_in     = out_last_ff;

      if (csr_valid) begin
         case (csr_index)
            REG_ROW_LENGTH:   row_length_in   = csr_data;
            REG_OUTPUT_COUNT: output_count_in = csr_data;
            default: ;
         endcase
      end

      // Latch the item and its window decisions; advance the row position.
      if (cmd.accept) begin
         sample_in   = req_tdata;
         win_in      = win_eff;
         need_sub_in = LEN_BITS'(pos_ff) >= win_eff;
         emit_in     = pos_next >= win_eff;
         row_end_in  = pos_next >= row_len_eff;
         pos_in      = (pos_next >= row_len_eff) ? '0 : pos_next[ADDR_BITS-1:0];
      end

      // Update the sum and load the divider with its magnitude.
      if (cmd.fetch) begin
         ptr_in = ptr_ff + ADDR_BITS'(1);
         sum_in = row_end_ff ? '0 : new_sum;
         neg_in = new_sum[SUM_BITS-1];
         quo_in = new_sum[SUM_BITS-1] ? SUM_BITS'(-new_sum) : SUM_BITS'(new_sum);
         rem_in = '0;
         cnt_in = '0;
      end

      if (cmd.div_step) begin
         if (!trial[LEN_BITS]) begin
            rem_in = trial[LEN_BITS-1:0];
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[LEN_BITS-1:0];
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_BITS'(1);
      end

      if (rsp_tready) out_valid_in = 1'b0;
      // Saturate the quotient to the sample range and apply the sign.
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
         out_last_in  = row_end_ff;
         if (neg_ff) begin
            avg_in = (quo_ff > MAG_NEG_LIMIT) ? AVG_MIN : neg_quo[SAMPLE_BITS-1:0];
         end else begin
            avg_in = (quo_ff > MAG_POS_LIMIT) ? AVG_MAX : quo_ff[SAMPLE_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff   <= ROW_LENGTH_RESET;
         output_count_ff <= OUTPUT_COUNT_RESET;
         pos_ff          <= '0;
         ptr_ff          <= '0;
         sum_ff          <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         row_length_ff   <= row_length_in;
         output_count_ff <= output_count_in;
         pos_ff          <= pos_in;
         ptr_ff          <= ptr_in;
         sum_ff          <= sum_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      win_ff      <= win_in;
      need_sub_ff <= need_sub_in;
      emit_ff     <= emit_in;
      row_end_ff  <= row_end_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      neg_ff      <= neg_in;
      cnt_ff      <= cnt_in;
      avg_ff      <= avg_in;
      out_last_ff <= out_last_in;
   end

   assign status.emit     = emit_ff;
   assign status.div_last = cnt_ff == CNT_LAST;
   assign status.out_free = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = avg_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

// ===== sv/row_moving_average.sv =====
// ----------------------------------------------------------------------------
// row_moving_average
// Boxcar moving average over rows of signed samples.
// ----------------------------------------------------------------------------
// Samples arrive on req_ one at a time; each row holds row_length samples and
// yields output_count averages over windows of row_length - output_count + 1
// samples, truncated toward zero, the last one flagged by rsp_tlast. A sample
// that yields an average runs the restoring divider, which retires one
// quotient bit per cycle over the 26-bit window sum, and may wait while the
// previous average still sits unclaimed in the output register. The output
// register lets the next sample be taken while an average waits on rsp_.
// The window store is a 256-entry RAM with one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module row_moving_average (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [rma_pkg::IDX_BITS-1:0]    csr_index,
   input  wire logic [rma_pkg::CFG_BITS-1:0]    csr_data,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [rma_pkg::SAMPLE_BITS-1:0] req_tdata,  // [15:0] sample
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [rma_pkg::SAMPLE_BITS-1:0]      rsp_tdata,  // [15:0] average
   output logic                                 rsp_tlast   // last_of_row
);
   import rma_pkg::*;

   cmd_type    cmd;
   status_type status;

   rma_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rma_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== sv/rma_checker.sv =====
// ----------------------------------------------------------------------------
// rma_checker
// Port-level checks on the row moving average, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rma_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [rma_pkg::SAMPLE_BITS-1:0] rsp_tdata,
   input wire logic                            rsp_tlast
);
   import rma_pkg::*;

   // One item at a time: the cycle after a take is spent on the window.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken twice in a row");

   // An average needs the divider; none can appear right after a take.
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !$rose(rsp_tvalid))
      else $error("result appeared one cycle after input");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("rsp payload changed while stalled");

endmodule

bind row_moving_average rma_checker u_rma_checker (.*);

`default_nettype wire
